/* rtl/feedback_loop_recorder_assert.svh */
// Assertion macros shared by the looper RTL.
// No dependencies; files that check their own logic include this header.
`ifndef FEEDBACK_LOOP_RECORDER_ASSERT_SVH
`define FEEDBACK_LOOP_RECORDER_ASSERT_SVH
`ifndef SYNTHESIS
`define FLR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FLR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLR_ASSERT(label, clk, rst, prop, msg)
`define FLR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/flr_pkg.sv */
// Shared types and constants of the feedback loop recorder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package flr_pkg;

   localparam int SAMPLE_BITS      = 16;
   localparam int CHANNELS         = 2;
   localparam int MAX_LOOP_SAMPLES = 65536;
   localparam int FRAME_BITS       = 2 * SAMPLE_BITS;
   localparam int GAIN_BITS        = 16;
   localparam int GAIN_FRAC        = 15;
   localparam int LEN_BITS         = 17;
   localparam int POS_BITS         = 16;
   localparam int COUNT_BITS       = 16;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int CSR_DATA_BITS    = 17;
   // product of unsigned gain and signed sample, one sign bit of headroom
   localparam int PROD_BITS        = GAIN_BITS + SAMPLE_BITS + 1;

   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_SEEK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOOP_LENGTH   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_GAIN = 1'b1;

   localparam logic [LEN_BITS-1:0]  LOOP_LENGTH_RESET = 17'd65536;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET        = 16'd29491;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_L,
      ST_MUL_R,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                          enable;
      logic [GAIN_BITS-1:0]          gain;
      logic signed [SAMPLE_BITS-1:0] stored;
      logic signed [SAMPLE_BITS-1:0] sample;
   } mix_ctl_type;

endpackage
`default_nettype wire

/* rtl/flr_mix_unit.sv */
// Shared feedback mixer: registered gain multiply, then round, add and saturate.
// Depends on flr_pkg; used once per channel in turn by the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module flr_mix_unit (
   input  wire logic                                  clock,
   input  wire flr_pkg::mix_ctl_type                  mix_ctl,
   output logic signed [flr_pkg::SAMPLE_BITS-1:0]     mix_sum
);

   localparam int PW = flr_pkg::PROD_BITS;
   localparam int SW = flr_pkg::SAMPLE_BITS;
   localparam int QW = PW - flr_pkg::GAIN_FRAC;
   localparam int AW = SW + 3;
   localparam logic signed [AW-1:0] SAT_MAX = AW'((1 << (SW - 1)) - 1);
   localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);
   localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1 << (flr_pkg::GAIN_FRAC - 1));

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] rounded;
   logic signed [QW-1:0] scaled;
   logic signed [AW-1:0] sum_wide;

   assign prod_in = $signed({1'b0, mix_ctl.gain}) * mix_ctl.stored;

   always_ff @(posedge clock) begin
      if (mix_ctl.enable) begin
         prod_ff <= prod_in;
      end
   end

   // floor of the biased product rounds half up
   always_comb begin
      rounded  = prod_ff + ROUND_BIAS;
      scaled   = rounded[PW-1:flr_pkg::GAIN_FRAC];
      sum_wide = AW'(mix_ctl.sample) + AW'(scaled);
      if (sum_wide > SAT_MAX) begin
         mix_sum = SAT_MAX[SW-1:0];
      end else if (sum_wide < SAT_MIN) begin
         mix_sum = SAT_MIN[SW-1:0];
      end else begin
         mix_sum = sum_wide[SW-1:0];
      end
   end

endmodule
`default_nettype wire

/* rtl/flr_store.sv */
// Loop store: one frame per entry, one write port and one registered read port.
// Depends on flr_pkg for the frame width.
`timescale 1ns / 1ps
`default_nettype none
module flr_store #(
   parameter int DEPTH  = flr_pkg::MAX_LOOP_SAMPLES,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [ADDR_W-1:0]              wr_addr,
   input  wire logic [flr_pkg::FRAME_BITS-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]              rd_addr,
   output logic      [flr_pkg::FRAME_BITS-1:0] rd_data
);

   logic [flr_pkg::FRAME_BITS-1:0] mem [DEPTH];
   logic [flr_pkg::FRAME_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/flr_seq.sv */
// Sequencer: item capture, loop position and pass count, store sweep, result register.
// Depends on flr_pkg and the assertion header; drives flr_store and flr_mix_unit.
`timescale 1ns / 1ps
`default_nettype none
`include "feedback_loop_recorder_assert.svh"
module flr_seq #(
   parameter int MAX_LOOP_SAMPLES = flr_pkg::MAX_LOOP_SAMPLES,
   parameter int ADDR_W = $clog2(MAX_LOOP_SAMPLES)
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [1:0]                             req_op,
   input  wire logic                                   req_playing,
   input  wire logic signed [flr_pkg::SAMPLE_BITS-1:0] req_in_left,
   input  wire logic signed [flr_pkg::SAMPLE_BITS-1:0] req_in_right,
   input  wire logic [flr_pkg::POS_BITS-1:0]           req_seek_position,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [flr_pkg::SAMPLE_BITS-1:0]      rsp_out_left,
   output logic signed [flr_pkg::SAMPLE_BITS-1:0]      rsp_out_right,
   output logic [flr_pkg::POS_BITS-1:0]                rsp_loop_position,
   output logic [flr_pkg::COUNT_BITS-1:0]              rsp_loop_count,
   output logic                                        rsp_was_reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [flr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [flr_pkg::CSR_DATA_BITS-1:0]      csr_wr_data,
   output logic                                        st_wr_en,
   output logic [ADDR_W-1:0]                           st_wr_addr,
   output logic [flr_pkg::FRAME_BITS-1:0]              st_wr_data,
   output logic [ADDR_W-1:0]                           st_rd_addr,
   input  wire logic [flr_pkg::FRAME_BITS-1:0]         st_rd_data,
   output flr_pkg::mix_ctl_type                        mix_ctl,
   input  wire logic signed [flr_pkg::SAMPLE_BITS-1:0] mix_sum
);

   localparam int SW        = flr_pkg::SAMPLE_BITS;
   // position always stays below POS_LIMIT, the store depth capped at 2^LEN_BITS
   localparam int POS_LIMIT = (MAX_LOOP_SAMPLES < (1 << flr_pkg::LEN_BITS)) ?
                              MAX_LOOP_SAMPLES : (1 << flr_pkg::LEN_BITS);
   localparam int POS_W     = $clog2(POS_LIMIT);
   localparam int LEN_W     = ((ADDR_W + 1 > flr_pkg::LEN_BITS) ?
                              ADDR_W + 1 : flr_pkg::LEN_BITS) + 1;
   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(MAX_LOOP_SAMPLES - 1);

   flr_pkg::state_type state_ff, state_in;

   logic [flr_pkg::LEN_BITS-1:0]   loop_length_ff;
   logic [flr_pkg::GAIN_BITS-1:0]  gain_ff;
   logic [POS_W-1:0]               position_ff, position_in;
   logic [flr_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                           flag_ff;
   logic                           sweep_ff;
   logic [ADDR_W-1:0]              sweep_addr_ff;

   logic [1:0]                     op_ff;
   logic                           playing_ff;
   logic signed [SW-1:0]           in_left_ff, in_right_ff;
   logic [flr_pkg::POS_BITS-1:0]   seek_ff;
   logic signed [SW-1:0]           left_sum_ff;

   logic                           rsp_valid_ff;
   logic signed [SW-1:0]           rsp_left_ff, rsp_right_ff, res_left_in, res_right_in;
   logic [flr_pkg::POS_BITS-1:0]   rsp_pos_ff;
   logic [flr_pkg::COUNT_BITS-1:0] rsp_count_ff;
   logic                           rsp_flag_ff, flag_report_in;

   logic                           ready;
   logic                           accept;
   logic                           rsp_free;
   logic                           finish_fire;
   logic                           mul_active;
   logic                           wr_mix;
   logic                           sweep_start;
   logic [LEN_W-1:0]               len_eff;
   logic [LEN_W-1:0]               pos_inc;
   logic [SW-1:0]                  right_keep;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && ready;

   // effective length: loop_length clamped to 1 .. store depth
   always_comb begin
      if (loop_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (LEN_W'(loop_length_ff) > LEN_W'(MAX_LOOP_SAMPLES)) begin
         len_eff = LEN_W'(MAX_LOOP_SAMPLES);
      end else begin
         len_eff = LEN_W'(loop_length_ff);
      end
   end

   assign pos_inc = LEN_W'(position_ff) + LEN_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         flr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_op == flr_pkg::OP_FRAME && req_playing) ?
                          flr_pkg::ST_MUL_L : flr_pkg::ST_FINISH;
            end
         end
         flr_pkg::ST_MUL_L:  state_in = flr_pkg::ST_MUL_R;
         flr_pkg::ST_MUL_R:  state_in = flr_pkg::ST_FINISH;
         flr_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = flr_pkg::ST_IDLE;
            end
         end
         default: state_in = flr_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      ready       = 1'b0;
      mul_active  = 1'b0;
      finish_fire = 1'b0;
      case (state_ff)
         flr_pkg::ST_IDLE:   ready = !sweep_ff;
         flr_pkg::ST_MUL_L:  mul_active = 1'b1;
         flr_pkg::ST_MUL_R:  mul_active = 1'b1;
         flr_pkg::ST_FINISH: finish_fire = rsp_free;
         default: ;
      endcase
   end

   assign req_stall = !ready;

   // left product in the first pass, right product in the second
   always_comb begin
      mix_ctl.enable = mul_active;
      mix_ctl.gain   = gain_ff;
      mix_ctl.stored = (state_ff == flr_pkg::ST_MUL_L) ? st_rd_data[SW-1:0] :
                       st_rd_data[2*SW-1:SW];
      mix_ctl.sample = (state_ff == flr_pkg::ST_MUL_R) ? in_left_ff : in_right_ff;
   end

   // effect of the finished item
   always_comb begin
      res_left_in    = '0;
      res_right_in   = '0;
      position_in    = position_ff;
      count_in       = count_ff;
      wr_mix         = 1'b0;
      sweep_start    = 1'b0;
      flag_report_in = flag_ff;
      right_keep     = st_rd_data[2*SW-1:SW];
      case (op_ff)
         flr_pkg::OP_FRAME: begin
            res_left_in  = in_left_ff;
            res_right_in = in_right_ff;
            if (playing_ff) begin
               wr_mix      = 1'b1;
               res_left_in = left_sum_ff;
               if (flr_pkg::CHANNELS > 1) begin
                  res_right_in = mix_sum;
                  right_keep   = mix_sum;
               end
               if (pos_inc >= len_eff) begin
                  position_in = '0;
                  count_in    = count_ff + 1'b1;
               end else begin
                  position_in = pos_inc[POS_W-1:0];
               end
            end
         end
         flr_pkg::OP_SEEK: begin
            flag_report_in = 1'b1;
            if (LEN_W'(seek_ff) >= len_eff) begin
               position_in = '0;
            end else begin
               position_in = POS_W'(seek_ff);
            end
         end
         flr_pkg::OP_CLEAR: begin
            flag_report_in = 1'b1;
            position_in    = '0;
            count_in       = '0;
            sweep_start    = 1'b1;
         end
         default: ;
      endcase
   end

   // sweep writes zero and owns the write port while it runs
   always_comb begin
      st_rd_addr = ADDR_W'(position_ff);
      if (sweep_ff) begin
         st_wr_en   = 1'b1;
         st_wr_addr = sweep_addr_ff;
         st_wr_data = '0;
      end else begin
         st_wr_en   = finish_fire && wr_mix;
         st_wr_addr = ADDR_W'(position_ff);
         st_wr_data = {right_keep, left_sum_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= flr_pkg::ST_IDLE;
         loop_length_ff <= flr_pkg::LOOP_LENGTH_RESET;
         gain_ff        <= flr_pkg::GAIN_RESET;
         position_ff    <= '0;
         count_ff       <= '0;
         flag_ff        <= 1'b1;
         sweep_ff       <= 1'b1;
         sweep_addr_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               flr_pkg::CSR_LOOP_LENGTH:   loop_length_ff <= csr_wr_data;
               flr_pkg::CSR_FEEDBACK_GAIN: gain_ff <= csr_wr_data[flr_pkg::GAIN_BITS-1:0];
               default: ;
            endcase
         end
         if (sweep_ff) begin
            sweep_addr_ff <= sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == SWEEP_LAST) begin
               sweep_ff <= 1'b0;
            end
         end else if (finish_fire && sweep_start) begin
            sweep_ff      <= 1'b1;
            sweep_addr_ff <= '0;
         end
         if (finish_fire) begin
            position_ff  <= position_in;
            count_ff     <= count_in;
            flag_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         playing_ff  <= req_playing;
         in_left_ff  <= req_in_left;
         in_right_ff <= req_in_right;
         seek_ff     <= req_seek_position;
      end
      if (state_ff == flr_pkg::ST_MUL_R) begin
         left_sum_ff <= mix_sum;
      end
      if (finish_fire) begin
         rsp_left_ff  <= res_left_in;
         rsp_right_ff <= res_right_in;
         rsp_pos_ff   <= flr_pkg::POS_BITS'(position_in);
         rsp_count_ff <= count_in;
         rsp_flag_ff  <= flag_report_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_left      = rsp_left_ff;
   assign rsp_out_right     = rsp_right_ff;
   assign rsp_loop_position = rsp_pos_ff;
   assign rsp_loop_count    = rsp_count_ff;
   assign rsp_was_reset     = rsp_flag_ff;

   `FLR_ASSERT_ALWAYS(a_sweep_blocks_items, clock, sweep_ff |-> req_stall, "item taken during sweep")
   `FLR_ASSERT_ALWAYS(a_busy_blocks_items, clock, (state_ff != flr_pkg::ST_IDLE) |-> req_stall, "item taken while busy")
   `FLR_ASSERT(a_no_mix_in_sweep, clock, reset, sweep_ff |-> !mix_ctl.enable, "mix pass during sweep")
   `FLR_ASSERT(a_finish_returns, clock, reset, (finish_fire) |=> (state_ff == flr_pkg::ST_IDLE), "finish did not return to idle")
   `FLR_ASSERT(a_position_bound, clock, reset, position_ff <= POS_W'(POS_LIMIT - 1), "position beyond store")

endmodule
`default_nettype wire

/* rtl/feedback_loop_recorder.sv */
// Stereo feedback looper. For a frame item while playing, the stored frame is read at the
// accepting edge, then two passes use the single shared gain multiplier (left, then
// right), then a finishing step saturates the right sample, writes back and loads the
// result register once the result side is free. Seek, clear, pass-through frames and the
// unused op go straight from acceptance to the finishing step. Each item returns to idle
// before the next one is accepted. The result register holds a finished item while the
// next one is already being captured. After reset and after every clear item, the store
// is swept to zero at one entry per cycle over all MAX_LOOP_SAMPLES entries, during which
// no item is accepted; configuration writes are taken at any time and must only change
// while idle.
// Depends on flr_pkg, flr_seq, flr_store and flr_mix_unit.
`timescale 1ns / 1ps
`default_nettype none
module feedback_loop_recorder #(
   parameter int MAX_LOOP_SAMPLES = flr_pkg::MAX_LOOP_SAMPLES
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [1:0]                             req_op,
   input  wire logic                                   req_playing,
   input  wire logic signed [flr_pkg::SAMPLE_BITS-1:0] req_in_left,
   input  wire logic signed [flr_pkg::SAMPLE_BITS-1:0] req_in_right,
   input  wire logic [flr_pkg::POS_BITS-1:0]           req_seek_position,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [flr_pkg::SAMPLE_BITS-1:0]      rsp_out_left,
   output logic signed [flr_pkg::SAMPLE_BITS-1:0]      rsp_out_right,
   output logic [flr_pkg::POS_BITS-1:0]                rsp_loop_position,
   output logic [flr_pkg::COUNT_BITS-1:0]              rsp_loop_count,
   output logic                                        rsp_was_reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [flr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [flr_pkg::CSR_DATA_BITS-1:0]      csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_LOOP_SAMPLES);

   logic                                st_wr_en;
   logic [ADDR_W-1:0]                   st_wr_addr;
   logic [flr_pkg::FRAME_BITS-1:0]      st_wr_data;
   logic [ADDR_W-1:0]                   st_rd_addr;
   logic [flr_pkg::FRAME_BITS-1:0]      st_rd_data;
   flr_pkg::mix_ctl_type                mix_ctl;
   logic signed [flr_pkg::SAMPLE_BITS-1:0] mix_sum;

   flr_seq #(
      .MAX_LOOP_SAMPLES(MAX_LOOP_SAMPLES),
      .ADDR_W(ADDR_W)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_playing(req_playing),
      .req_in_left(req_in_left),
      .req_in_right(req_in_right),
      .req_seek_position(req_seek_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_left(rsp_out_left),
      .rsp_out_right(rsp_out_right),
      .rsp_loop_position(rsp_loop_position),
      .rsp_loop_count(rsp_loop_count),
      .rsp_was_reset(rsp_was_reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data),
      .st_wr_en(st_wr_en),
      .st_wr_addr(st_wr_addr),
      .st_wr_data(st_wr_data),
      .st_rd_addr(st_rd_addr),
      .st_rd_data(st_rd_data),
      .mix_ctl(mix_ctl),
      .mix_sum(mix_sum)
   );

   flr_store #(
      .DEPTH(MAX_LOOP_SAMPLES),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock(clock),
      .wr_en(st_wr_en),
      .wr_addr(st_wr_addr),
      .wr_data(st_wr_data),
      .rd_addr(st_rd_addr),
      .rd_data(st_rd_data)
   );

   flr_mix_unit u_mix (
      .clock(clock),
      .mix_ctl(mix_ctl),
      .mix_sum(mix_sum)
   );

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking bench for feedback_loop_recorder: a directed stimulus table, then four
// randomized phases with varied idling; each result checked by table or bench looper.
// Depends on flr_pkg and the feedback_loop_recorder RTL.
`timescale 1ns / 1ps
module testbench;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int PHASE_ITEMS  = 335;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_PAUSE  = 6;
   localparam int MAX_CLEARS   = 4;
   localparam longint SAMPLE_MAX = 2 ** (flr_pkg::SAMPLE_BITS - 1) - 1;
   localparam longint SAMPLE_MIN = -(2 ** (flr_pkg::SAMPLE_BITS - 1));

   typedef struct packed {
      logic [1:0]                             op;
      logic                                   playing;
      logic signed [flr_pkg::SAMPLE_BITS-1:0] left;
      logic signed [flr_pkg::SAMPLE_BITS-1:0] right;
      logic [flr_pkg::POS_BITS-1:0]           seek;
   } frame_req_type;

   typedef struct packed {
      logic signed [flr_pkg::SAMPLE_BITS-1:0] left;
      logic signed [flr_pkg::SAMPLE_BITS-1:0] right;
      logic [flr_pkg::POS_BITS-1:0]           position;
      logic [flr_pkg::COUNT_BITS-1:0]         count;
      logic                                   was_reset;
   } frame_rsp_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                       kind;
      frame_req_type                      req;
      logic [flr_pkg::CSR_INDEX_BITS-1:0] csr_idx;
      logic [flr_pkg::CSR_DATA_BITS-1:0]  csr_val;
      logic                               typed;
      frame_rsp_type                      want;
   } plan_row_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic [1:0]                             req_op = flr_pkg::OP_FRAME;
   logic                                   req_playing = 1'b0;
   logic signed [flr_pkg::SAMPLE_BITS-1:0] req_in_left = '0;
   logic signed [flr_pkg::SAMPLE_BITS-1:0] req_in_right = '0;
   logic [flr_pkg::POS_BITS-1:0]           req_seek_position = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic signed [flr_pkg::SAMPLE_BITS-1:0] rsp_out_left;
   logic signed [flr_pkg::SAMPLE_BITS-1:0] rsp_out_right;
   logic [flr_pkg::POS_BITS-1:0]           rsp_loop_position;
   logic [flr_pkg::COUNT_BITS-1:0]         rsp_loop_count;
   logic                                   rsp_was_reset;
   logic                                   csr_wr_en = 1'b0;
   logic [flr_pkg::CSR_INDEX_BITS-1:0]     csr_index = flr_pkg::CSR_LOOP_LENGTH;
   logic [flr_pkg::CSR_DATA_BITS-1:0]      csr_wr_data = '0;

   feedback_loop_recorder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_playing      (req_playing),
      .req_in_left      (req_in_left),
      .req_in_right     (req_in_right),
      .req_seek_position(req_seek_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .rsp_loop_position(rsp_loop_position),
      .rsp_loop_count   (rsp_loop_count),
      .rsp_was_reset    (rsp_was_reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   // looper state mirrored by the bench
   logic signed [flr_pkg::SAMPLE_BITS-1:0] loop_left  [flr_pkg::MAX_LOOP_SAMPLES];
   logic signed [flr_pkg::SAMPLE_BITS-1:0] loop_right [flr_pkg::MAX_LOOP_SAMPLES];
   int unsigned                            play_pos;
   logic [flr_pkg::COUNT_BITS-1:0]         pass_total;
   logic                                   flag_pending;
   logic [flr_pkg::LEN_BITS-1:0]           len_reg;
   logic [flr_pkg::GAIN_BITS-1:0]          gain_reg;

   frame_rsp_type pending[$];
   frame_rsp_type oldest;
   plan_row_type  plan[$];

   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int wraps_seen = 0;
   int sat_hits = 0;
   int clears_left = MAX_CLEARS;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;

   function automatic void wipe_loop();
      for (int i = 0; i < flr_pkg::MAX_LOOP_SAMPLES; i++) begin
         loop_left[i]  = '0;
         loop_right[i] = '0;
      end
   endfunction

   function automatic int unsigned loop_span();
      if (len_reg == 0) return 1;
      if (len_reg > flr_pkg::MAX_LOOP_SAMPLES) return flr_pkg::MAX_LOOP_SAMPLES;
      return len_reg;
   endfunction

   function automatic logic signed [flr_pkg::SAMPLE_BITS-1:0] feed_mix(
      logic signed [flr_pkg::SAMPLE_BITS-1:0] dry,
      logic signed [flr_pkg::SAMPLE_BITS-1:0] held);
      longint prod;
      longint sum;
      // arithmetic shift floors, so the +16384 rounds half up
      prod = longint'(gain_reg) * longint'(held) + 64'sd16384;
      sum = longint'(dry) + (prod >>> flr_pkg::GAIN_FRAC);
      if (sum > SAMPLE_MAX) begin
         sum = SAMPLE_MAX;
         sat_hits++;
      end else if (sum < SAMPLE_MIN) begin
         sum = SAMPLE_MIN;
         sat_hits++;
      end
      return sum[flr_pkg::SAMPLE_BITS-1:0];
   endfunction

   function automatic frame_rsp_type looper_step(frame_req_type it);
      frame_rsp_type r;
      int unsigned   span;
      int unsigned   idx;
      span = loop_span();
      r = '0;
      case (it.op)
         flr_pkg::OP_FRAME: begin
            r.left  = it.left;
            r.right = it.right;
            if (it.playing) begin
               idx = play_pos & (flr_pkg::MAX_LOOP_SAMPLES - 1);
               r.left  = feed_mix(it.left, loop_left[idx]);
               r.right = feed_mix(it.right, loop_right[idx]);
               loop_left[idx]  = r.left;
               loop_right[idx] = r.right;
               // wrap also when the length shrank below the position
               if (play_pos + 1 >= span) begin
                  play_pos = 0;
                  pass_total++;
                  wraps_seen++;
               end else begin
                  play_pos++;
               end
            end
         end
         flr_pkg::OP_SEEK: begin
            play_pos = (it.seek >= span) ? 0 : it.seek;
            flag_pending = 1'b1;
         end
         flr_pkg::OP_CLEAR: begin
            wipe_loop();
            play_pos = 0;
            pass_total = '0;
            flag_pending = 1'b1;
         end
         default: ;
      endcase
      r.position  = play_pos[flr_pkg::POS_BITS-1:0];
      r.count     = pass_total;
      r.was_reset = flag_pending;
      flag_pending = 1'b0;
      return r;
   endfunction

   function automatic plan_row_type row_item(logic [1:0] op, logic play, int l, int r,
                                             int seek);
      plan_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.req.op = op;
      row.req.playing = play;
      row.req.left = flr_pkg::SAMPLE_BITS'(l);
      row.req.right = flr_pkg::SAMPLE_BITS'(r);
      row.req.seek = flr_pkg::POS_BITS'(seek);
      return row;
   endfunction

   function automatic plan_row_type row_checked(logic [1:0] op, logic play, int l, int r,
                                                int seek, int el, int er, int pos, int cnt,
                                                logic flag);
      plan_row_type row;
      row = row_item(op, play, l, r, seek);
      row.typed = 1'b1;
      row.want.left = flr_pkg::SAMPLE_BITS'(el);
      row.want.right = flr_pkg::SAMPLE_BITS'(er);
      row.want.position = flr_pkg::POS_BITS'(pos);
      row.want.count = flr_pkg::COUNT_BITS'(cnt);
      row.want.was_reset = flag;
      return row;
   endfunction

   function automatic plan_row_type row_csr(logic [flr_pkg::CSR_INDEX_BITS-1:0] idx,
                                            int unsigned value);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = flr_pkg::CSR_DATA_BITS'(value);
      return row;
   endfunction

   function automatic logic signed [flr_pkg::SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return {1'b0, {(flr_pkg::SAMPLE_BITS-1){1'b1}}};
         1:       return {1'b1, {(flr_pkg::SAMPLE_BITS-1){1'b0}}};
         2:       return flr_pkg::SAMPLE_BITS'($urandom_range(0, 31))
                         - flr_pkg::SAMPLE_BITS'(16);
         default: return flr_pkg::SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic frame_req_type random_frame();
      frame_req_type it;
      int unsigned   roll;
      int unsigned   span;
      span = loop_span();
      it.op = flr_pkg::OP_FRAME;
      it.playing = 1'b1;
      it.left = pick_sample();
      it.right = pick_sample();
      it.seek = flr_pkg::POS_BITS'($urandom);
      roll = $urandom_range(99);
      if (roll < 3) begin
         it.op = OP_UNUSED;
         it.playing = 1'($urandom);
      end else if (roll < 9) begin
         it.op = flr_pkg::OP_SEEK;
         it.playing = 1'($urandom);
         // aim near the loop end to force wraps on long loops
         case ($urandom_range(2))
            0:       it.seek = flr_pkg::POS_BITS'(span - $urandom_range(1,
                                                   (span > 3) ? 3 : span));
            1:       it.seek = flr_pkg::POS_BITS'($urandom_range(0, span + 1));
            default: ;
         endcase
      end else if (roll == 9 && clears_left > 0 && $urandom_range(3) == 0) begin
         it.op = flr_pkg::OP_CLEAR;
         it.playing = 1'($urandom);
         clears_left--;
      end else if (roll < 22) begin
         it.playing = 1'b0;
      end
      return it;
   endfunction

   task automatic offer(input frame_req_type it, output frame_rsp_type predicted);
      csr_wr_en <= 1'b0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_op <= 2'($urandom);
         req_playing <= 1'($urandom);
         req_in_left <= flr_pkg::SAMPLE_BITS'($urandom);
         req_in_right <= flr_pkg::SAMPLE_BITS'($urandom);
         req_seek_position <= flr_pkg::POS_BITS'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= it.op;
      req_playing <= it.playing;
      req_in_left <= it.left;
      req_in_right <= it.right;
      req_seek_position <= it.seek;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = looper_step(it);
      items_sent++;
      @(negedge clock);
   endtask

   // drop valid and wait until every outstanding item has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
      @(negedge clock);
   endtask

   // leaves the write enable high; the next item lowers it
   task automatic write_reg(input logic [flr_pkg::CSR_INDEX_BITS-1:0] idx,
                            input int unsigned value);
      csr_index <= idx;
      csr_wr_data <= flr_pkg::CSR_DATA_BITS'(value);
      csr_wr_en <= 1'b1;
      @(posedge clock);
      if (idx == flr_pkg::CSR_LOOP_LENGTH) len_reg = flr_pkg::LEN_BITS'(value);
      else gain_reg = flr_pkg::GAIN_BITS'(value);
      @(negedge clock);
   endtask

   task automatic compare_field(input string what, input logic signed [31:0] want_v,
                                input logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, got L=%0d R=%0d pos=%0d",
                     $time, rsp_out_left, rsp_out_right, rsp_loop_position);
            errors++;
         end else begin
            oldest = pending.pop_front();
            compare_field("out_left", oldest.left, rsp_out_left);
            compare_field("out_right", oldest.right, rsp_out_right);
            compare_field("loop_position", oldest.position, rsp_loop_position);
            compare_field("loop_count", oldest.count, rsp_loop_count);
            compare_field("was_reset", oldest.was_reset, rsp_was_reset);
            results_checked++;
         end
      end
   end

   // result-side stall; a requested hold-off blocks it for a long stretch
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending.size());
         $display("feedback_loop_recorder verification failed");
         $finish;
      end
   end

   initial begin
      frame_rsp_type predicted;
      int            directed_items;
      int unsigned   len_pick;
      int unsigned   gain_pick;

      wipe_loop();
      play_pos = 0;
      pass_total = '0;
      flag_pending = 1'b1;
      len_reg = flr_pkg::LOOP_LENGTH_RESET;
      gain_reg = flr_pkg::GAIN_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: gain 0.9, full-depth loop
      plan.push_back(row_checked(flr_pkg::OP_FRAME, 1, 32767, -32768, 0,
                                 32767, -32768, 1, 0, 1));
      plan.push_back(row_checked(flr_pkg::OP_FRAME, 0, 4660, -5, 0, 4660, -5, 1, 0, 0));
      plan.push_back(row_checked(flr_pkg::OP_SEEK, 1, 0, 0, 65535, 0, 0, 65535, 0, 1));
      plan.push_back(row_checked(flr_pkg::OP_FRAME, 1, -1, 1, 0, -1, 1, 0, 1, 0));
      plan.push_back(row_item(flr_pkg::OP_FRAME, 1, 100, -100, 0));
      plan.push_back(row_checked(OP_UNUSED, 1, -32768, 32767, 65535, 0, 0, 1, 1, 0));
      // zero length clamps to one, gain near 2.0 drives saturation
      plan.push_back(row_csr(flr_pkg::CSR_LOOP_LENGTH, 0));
      plan.push_back(row_csr(flr_pkg::CSR_FEEDBACK_GAIN, 65535));
      plan.push_back(row_checked(flr_pkg::OP_SEEK, 0, 0, 0, 0, 0, 0, 0, 1, 1));
      plan.push_back(row_item(flr_pkg::OP_FRAME, 1, 32767, -32768, 0));
      plan.push_back(row_item(flr_pkg::OP_FRAME, 1, 32767, -32768, 0));
      plan.push_back(row_item(flr_pkg::OP_FRAME, 1, 32767, -32768, 0));
      plan.push_back(row_item(flr_pkg::OP_FRAME, 1, -32768, 32767, 0));
      plan.push_back(row_item(flr_pkg::OP_SEEK, 1, 0, 0, 5));
      plan.push_back(row_csr(flr_pkg::CSR_LOOP_LENGTH, 131071));
      plan.push_back(row_item(flr_pkg::OP_SEEK, 0, 0, 0, 40000));
      plan.push_back(row_csr(flr_pkg::CSR_FEEDBACK_GAIN, 0));
      plan.push_back(row_item(flr_pkg::OP_FRAME, 1, 12345, -12345, 0));
      // shrink the loop under the current position without a clear
      plan.push_back(row_csr(flr_pkg::CSR_LOOP_LENGTH, 3));
      plan.push_back(row_item(flr_pkg::OP_FRAME, 1, -21846, 21845, 0));
      plan.push_back(row_checked(flr_pkg::OP_CLEAR, 1, 7, 7, 1234, 0, 0, 0, 0, 1));
      plan.push_back(row_csr(flr_pkg::CSR_FEEDBACK_GAIN, 32768));
      plan.push_back(row_checked(flr_pkg::OP_FRAME, 1, -32768, 32767, 0,
                                 -32768, 32767, 1, 0, 0));
      plan.push_back(row_item(flr_pkg::OP_FRAME, 0, 1, -1, 0));
      plan.push_back(row_csr(flr_pkg::CSR_LOOP_LENGTH, 65536));

      idle_pct = 20;
      stall_pct = 20;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_reg(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            offer(plan[i].req, predicted);
            pending.push_back(plan[i].typed ? plan[i].want : predicted);
         end
      end
      directed_items = items_sent;

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               len_pick = 8;      gain_pick = flr_pkg::GAIN_RESET;
               idle_pct = 0;      stall_pct = 0;
            end
            1: begin
               len_pick = 1;      gain_pick = 65535;
               idle_pct = 80;     stall_pct = 0;
            end
            2: begin
               len_pick = 131071; gain_pick = 16384;
               idle_pct = 0;      stall_pct = 80;
            end
            default: begin
               len_pick = $urandom_range(2, 40);
               gain_pick = $urandom_range(0, 65535);
               idle_pct = 32;
               stall_pct = 32;
            end
         endcase
         settle();
         write_reg(flr_pkg::CSR_LOOP_LENGTH, len_pick);
         write_reg(flr_pkg::CSR_FEEDBACK_GAIN, gain_pick);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long result-side hold-off while items keep coming
            if (ph == 0 && n == 60) hold_requests++;
            offer(random_frame(), predicted);
            pending.push_back(predicted);
         end
      end

      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);

      $display("Run covered %0d items (%0d from the directed table), %0d results checked.",
               items_sent, directed_items, results_checked);
      $display("Loop wraps %0d, saturated samples %0d, random clears %0d, %0d mismatches.",
               wraps_seen, sat_hits, MAX_CLEARS - clears_left, errors);
      if (errors == 0) begin
         $display("feedback_loop_recorder verification clean");
      end else begin
         $display("feedback_loop_recorder verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/flr_pkg.sv
rtl/flr_mix_unit.sv
rtl/flr_store.sv
rtl/flr_seq.sv
rtl/feedback_loop_recorder.sv
dv/testbench.sv
